// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk outside reset.
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/smtplt_pkg.sv
// Package for the SMTP session line tracker: types, constants, verb table.
`timescale 1ns / 1ps

package smtplt_pkg;

    // Line length saturation limit and the counter width it needs
    localparam int LINE_LIMIT = 1024;
    localparam int LEN_W      = $clog2(LINE_LIMIT + 1);

    // Command token storage
    localparam int TOKEN_KEEP = 5;
    localparam int TOK_IDX_W  = $clog2(TOKEN_KEEP);
    localparam int VERB_COUNT = 13;

    localparam int CODE_W = 10;
    localparam int CMD_W  = 4;

    localparam logic [CODE_W-1:0] CODE_START_DATA = 10'd354;

    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_DASH = 8'h2d;
    localparam logic [7:0] CH_DOT  = 8'h2e;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0b;
    localparam logic [7:0] CH_FF   = 8'h0c;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {
        ST_INIT = 2'd0,
        ST_RESP = 2'd1,
        ST_CMD  = 2'd2,
        ST_DATA = 2'd3
    } t_session;

    typedef enum logic [1:0] {
        LK_RESP      = 2'd0,
        LK_CMD       = 2'd1,
        LK_DATA      = 2'd2,
        LK_PARSE_ERR = 2'd3
    } t_line_kind;

    localparam logic [CMD_W-1:0] VERB_UNKNOWN = 4'd13;

    typedef logic [TOKEN_KEEP-1:0][7:0] t_token;

    // Upper-case fold, ASCII letters only
    function automatic logic [7:0] fold_upper(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) ? (c - 8'd32) : c;
    endfunction

    // Verb text, first character in the top byte, zero padded
    function automatic logic [TOKEN_KEEP*8-1:0] verb_text(int v);
        logic [TOKEN_KEEP*8-1:0] t;
        case (v)
            0:       t = {"AUTH", 8'h00};
            1:       t = {"DATA", 8'h00};
            2:       t = {"EHLO", 8'h00};
            3:       t = {"EXPN", 8'h00};
            4:       t = {"HELO", 8'h00};
            5:       t = {"HELP", 8'h00};
            6:       t = {"MAIL", 8'h00};
            7:       t = {"NOOP", 8'h00};
            8:       t = {"QUIT", 8'h00};
            9:       t = {"RCPT", 8'h00};
            10:      t = {"RSET", 8'h00};
            11:      t = {"VRFY", 8'h00};
            12:      t = "DEBUG";
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic int verb_len(int v);
        return (v == 12) ? 5 : 4;
    endfunction

    // Match the kept token against the verb table; lowest index wins
    function automatic logic [CMD_W-1:0] match_verb(t_token tok, logic [LEN_W-1:0] len);
        logic [CMD_W-1:0]        res;
        logic                    same;
        logic [TOKEN_KEEP*8-1:0] txt;
        res = VERB_UNKNOWN;
        for (int v = VERB_COUNT - 1; v >= 0; v--) begin
            txt  = verb_text(v);
            same = (len == LEN_W'(verb_len(v)));
            for (int k = 0; k < TOKEN_KEEP; k++) begin
                if (k < verb_len(v) &&
                    fold_upper(tok[k]) != txt[TOKEN_KEEP*8-1-8*k -: 8]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                res = CMD_W'(v);
            end
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/smtp_session_line_tracker_top.sv
// Top level of the SMTP session line tracker: line splitting and session state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// Input channel (i_valid / o_stall): one item per accepted edge. Opcode 0
// carries a stream byte of the direction the session awaits; opcode 1 starts
// a new session and clears the session and line state without giving a result.
// Output channel (o_valid / i_stall): one result item per completed line,
// i.e. per CR or LF, except an LF directly after a CR, which is dropped.
// Latency: a line's result is valid in the cycle after its terminator is
// accepted. Throughput: one item per cycle while o_stall is low.
// The block takes a new item while a result waits, as long as that result
// is taken in the same cycle; o_stall rises only when the result register is
// full and the receiver stalls, and the held result does not change.
// Reset (i_rst_n low at a clock edge): session state goes to init, all line
// counters clear, the result register empties.
module smtp_session_line_tracker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [0:0]                          i_opcode,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_line_kind,
    output logic [smtplt_pkg::CODE_W-1:0]       o_reply_code,
    output logic                                o_multi_line,
    output logic [smtplt_pkg::CMD_W-1:0]        o_command_id,
    output logic [smtplt_pkg::LEN_W-1:0]        o_line_length,
    output logic                                o_end_of_data,
    output logic [1:0]                          o_next_state
);
    import smtplt_pkg::*;

    // Session and line state
    t_session              r_state,       n_state;
    logic [LEN_W-1:0]      r_line_count,  n_line_count;
    logic [2:0]            r_digit_run,   n_digit_run;
    logic                  r_digits_done, n_digits_done;
    logic [CODE_W-1:0]     r_code,        n_code;
    logic                  r_dash,        n_dash;
    t_token                r_tok,         n_tok;
    logic [LEN_W-1:0]      r_tok_len,     n_tok_len;
    logic                  r_tok_closed,  n_tok_closed;
    logic                  r_first_dot,   n_first_dot;
    logic                  r_after_cr,    n_after_cr;

    // Result register
    logic                  r_out_valid,   n_out_valid;
    t_line_kind            r_kind;
    logic [CODE_W-1:0]     r_code_out;
    logic                  r_multi;
    logic [CMD_W-1:0]      r_cmd;
    logic [LEN_W-1:0]      r_len_out;
    logic                  r_eod;
    t_session              r_next;

    // Line-end result, computed from current state
    t_line_kind            res_kind;
    logic [CODE_W-1:0]     res_code;
    logic                  res_multi;
    logic [CMD_W-1:0]      res_cmd;
    logic                  res_eod;
    t_session              res_next;

    logic                  in_acc;
    logic                  is_end;
    logic                  emit;
    logic                  is_digit;
    logic                  is_blank;
    logic [7:0]            digit_val;

    assign o_stall  = r_out_valid & i_stall;
    assign in_acc   = i_valid & ~o_stall;
    assign is_end   = (i_data_byte == CH_CR) || (i_data_byte == CH_LF);
    assign is_digit = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
    assign is_blank = (i_data_byte == CH_SP) || (i_data_byte == CH_TAB) ||
                      (i_data_byte == CH_VT) || (i_data_byte == CH_FF);
    assign digit_val = i_data_byte - CH_ZERO;

    // Per-state line result
    always_comb begin
        res_kind  = LK_RESP;
        res_code  = '0;
        res_multi = 1'b0;
        res_cmd   = VERB_UNKNOWN;
        res_eod   = 1'b0;
        res_next  = r_state;
        unique case (r_state)
            ST_INIT, ST_RESP: begin
                if (r_digit_run == 3'd3) begin
                    res_kind  = LK_RESP;
                    res_code  = r_code;
                    res_multi = r_dash;
                    if (!r_dash) begin
                        res_next = (r_code == CODE_START_DATA) ? ST_DATA : ST_CMD;
                    end
                end else begin
                    res_kind = LK_PARSE_ERR;
                end
            end
            ST_CMD: begin
                res_kind = LK_CMD;
                res_cmd  = match_verb(r_tok, r_tok_len);
                res_next = ST_RESP;
            end
            ST_DATA: begin
                res_kind = LK_DATA;
                if (r_line_count == LEN_W'(1) && r_first_dot) begin
                    res_eod  = 1'b1;
                    res_next = ST_RESP;
                end
            end
            default: begin
                res_kind = LK_PARSE_ERR;
            end
        endcase
    end

    // Next state for one accepted item
    always_comb begin
        n_state       = r_state;
        n_line_count  = r_line_count;
        n_digit_run   = r_digit_run;
        n_digits_done = r_digits_done;
        n_code        = r_code;
        n_dash        = r_dash;
        n_tok         = r_tok;
        n_tok_len     = r_tok_len;
        n_tok_closed  = r_tok_closed;
        n_first_dot   = r_first_dot;
        n_after_cr    = r_after_cr;
        emit          = 1'b0;

        if (in_acc) begin
            if (i_opcode[0]) begin
                // new session
                n_state       = ST_INIT;
                n_after_cr    = 1'b0;
                n_line_count  = '0;
                n_digit_run   = '0;
                n_digits_done = 1'b0;
                n_code        = '0;
                n_dash        = 1'b0;
                n_tok_len     = '0;
                n_tok_closed  = 1'b0;
                n_first_dot   = 1'b0;
            end else if (!is_end) begin
                // ordinary byte
                n_after_cr = 1'b0;
                if (r_line_count == '0) begin
                    n_first_dot = (i_data_byte == CH_DOT);
                end
                if (r_line_count < LEN_W'(LINE_LIMIT)) begin
                    n_line_count = r_line_count + LEN_W'(1);
                end
                if (!r_digits_done) begin
                    if (is_digit) begin
                        if (r_digit_run < 3'd3) begin
                            n_code = CODE_W'(({4'b0, r_code} * 14'd10) + 14'(digit_val));
                        end
                        if (r_digit_run < 3'd4) begin
                            n_digit_run = r_digit_run + 3'd1;
                        end
                    end else begin
                        n_digits_done = 1'b1;
                        if (r_digit_run == 3'd3 && i_data_byte == CH_DASH) begin
                            n_dash = 1'b1;
                        end
                    end
                end
                if (!r_tok_closed) begin
                    if (is_blank) begin
                        n_tok_closed = 1'b1;
                    end else begin
                        if (r_tok_len < LEN_W'(TOKEN_KEEP)) begin
                            n_tok[r_tok_len[TOK_IDX_W-1:0]] = i_data_byte;
                        end
                        if (r_tok_len < LEN_W'(LINE_LIMIT)) begin
                            n_tok_len = r_tok_len + LEN_W'(1);
                        end
                    end
                end
            end else if (i_data_byte == CH_LF && r_after_cr) begin
                // LF of a CR LF pair
                n_after_cr = 1'b0;
            end else begin
                // line end
                emit          = 1'b1;
                n_after_cr    = (i_data_byte == CH_CR);
                n_state       = res_next;
                n_line_count  = '0;
                n_digit_run   = '0;
                n_digits_done = 1'b0;
                n_code        = '0;
                n_dash        = 1'b0;
                n_tok_len     = '0;
                n_tok_closed  = 1'b0;
                n_first_dot   = 1'b0;
            end
        end
    end

    // Result register valid
    always_comb begin
        n_out_valid = r_out_valid & i_stall;
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_INIT;
            r_line_count  <= '0;
            r_digit_run   <= '0;
            r_digits_done <= 1'b0;
            r_code        <= '0;
            r_dash        <= 1'b0;
            r_tok_len     <= '0;
            r_tok_closed  <= 1'b0;
            r_first_dot   <= 1'b0;
            r_after_cr    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_line_count  <= n_line_count;
            r_digit_run   <= n_digit_run;
            r_digits_done <= n_digits_done;
            r_code        <= n_code;
            r_dash        <= n_dash;
            r_tok_len     <= n_tok_len;
            r_tok_closed  <= n_tok_closed;
            r_first_dot   <= n_first_dot;
            r_after_cr    <= n_after_cr;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload: token characters and result fields
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (emit) begin
            r_kind     <= res_kind;
            r_code_out <= res_code;
            r_multi    <= res_multi;
            r_cmd      <= res_cmd;
            r_len_out  <= r_line_count;
            r_eod      <= res_eod;
            r_next     <= res_next;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_line_kind   = r_kind;
    assign o_reply_code  = r_code_out;
    assign o_multi_line  = r_multi;
    assign o_command_id  = r_cmd;
    assign o_line_length = r_len_out;
    assign o_end_of_data = r_eod;
    assign o_next_state  = r_next;

    // Checks
    `ASSERT_ALWAYS(a_stall_only_when_full, o_stall |-> r_out_valid, "stall with empty result register")
    `ASSERT_CLKD(a_restart_clears, (in_acc && i_opcode[0]) |=> (r_state == ST_INIT && r_line_count == '0 && !r_after_cr), "new session did not clear state")
    `ASSERT_CLKD(a_eod_returns_resp, (o_valid && o_end_of_data) |-> (o_line_kind == LK_DATA && o_next_state == ST_RESP), "end of data with wrong kind or state")
    `ASSERT_CLKD(a_code_only_on_resp, (o_valid && o_reply_code != '0) |-> (o_line_kind == LK_RESP), "reply code on a non-response line")

endmodule
